// ----- rtl/core/adsr_envelope_stereo_core_assert.svh -----
// ----------------------------------------------------------------------------
// adsr_envelope_stereo_core assertion macros
// Concurrent assertion helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_STEREO_CORE_ASSERT_SVH
`define ADSR_ENVELOPE_STEREO_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// pre in this cycle implies post in the same cycle
`define ADSR_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// pre in this cycle implies post in the next cycle
`define ADSR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`else

`define ADSR_ASSERT_SAME(label, clk, rst_n, pre, post)
`define ADSR_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- rtl/core/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, register indexes, reset values and interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COUNT_BITS_DEF = 24;
	localparam int LEN_W          = 24;
	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC      = 14;
	localparam int FRAC_BITS      = 2 * GAIN_FRAC;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = LEN_W;
	localparam int DIV_STEPS      = GAIN_W;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd5;

	// register reset values
	localparam logic [LEN_W-1:0]  RST_ATTACK_LEN  = 24'd2205;
	localparam logic [LEN_W-1:0]  RST_DECAY_LEN   = 24'd2205;
	localparam logic [LEN_W-1:0]  RST_RELEASE_LEN = 24'd2205;
	localparam logic [LEN_W-1:0]  RST_NOTE_LEN    = 24'd4410;
	localparam logic [GAIN_W-1:0] RST_PEAK_GAIN   = 16'd19661;
	localparam logic [GAIN_W-1:0] RST_OUTPUT_GAIN = 16'd16384;

	typedef struct packed {
		logic                          restart;
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic                          still_playing;
	} result_t;

	typedef struct packed {
		logic take_in;
		logic eval_phase;
		logic load_num;
		logic div_step;
		logic load_gain;
		logic mul_left;
		logic mul_right;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic direct;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/adsr_ctrl.sv -----
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer: steps one request through phase select, divide (skipped for a direct gain) and scaling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adsr_envelope_stereo_core_assert.svh"

module adsr_ctrl
	import adsr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sample_valid,
	output logic          sample_ready,
	output logic          result_valid,
	input  wire logic     result_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PHASE = 3'd1;
	localparam logic [2:0] S_NUM   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_GAIN  = 3'd4;
	localparam logic [2:0] S_MUL_L = 3'd5;
	localparam logic [2:0] S_MUL_R = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign slot_free    = !out_valid_q || result_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cmd.take_in = sample_valid && sample_ready;
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) state_d = S_PHASE;
			end
			S_PHASE: begin
				cmd.eval_phase = 1'b1;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.load_num = 1'b1;
				state_d = stat.direct ? S_GAIN : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) state_d = S_GAIN;
			end
			S_GAIN: begin
				cmd.load_gain = 1'b1;
				state_d = S_MUL_L;
			end
			S_MUL_L: begin
				cmd.mul_left = 1'b1;
				state_d = S_MUL_R;
			end
			S_MUL_R: begin
				cmd.mul_right = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				cmd.load_out = slot_free;
				if (slot_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_NUM) begin
				div_cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ADSR_ASSERT_NEXT(a_accept_starts, clk, arst_n, sample_valid && sample_ready, state_q == S_PHASE)
	`ADSR_ASSERT_NEXT(a_direct_skips_div, clk, arst_n, state_q == S_NUM && stat.direct, state_q == S_GAIN)
	`ADSR_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == S_DIV && div_cnt_q == DIV_LAST, state_q == S_GAIN)
	`ADSR_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load_out, result_valid)
	`ADSR_ASSERT_SAME(a_done_blocks, clk, arst_n, state_q == S_DONE && !slot_free, !cmd.load_out)

endmodule

`default_nettype wire

// ----- rtl/core/adsr_dp.sv -----
// ----------------------------------------------------------------------------
// adsr_dp
// Datapath: config registers, sample counter, gain divider, channel scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_dp
	import adsr_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire sample_t               sample,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	output result_t                    result
);

	localparam int CMP_W  = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 2;
	localparam int NUM_W  = GAIN_W + LEN_W;
	localparam int GG_W   = 2 * GAIN_W;
	localparam int PROD_W = SAMPLE_BITS + GG_W;
	localparam int RND_W  = PROD_W + 1 - FRAC_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [PROD_W:0]       ROUND_ADD = (PROD_W+1)'(1) << (FRAC_BITS - 1);
	localparam logic [RND_W-1:0]      HALF      = RND_W'(1) << (SAMPLE_BITS - 1);

	// config registers
	logic [LEN_W-1:0]  attack_len_q;
	logic [LEN_W-1:0]  decay_len_q;
	logic [LEN_W-1:0]  release_len_q;
	logic [LEN_W-1:0]  note_len_q;
	logic [GAIN_W-1:0] peak_gain_q;
	logic [GAIN_W-1:0] output_gain_q;

	logic [COUNT_BITS-1:0]  count_q;
	logic [COUNT_BITS-1:0]  t_q;
	logic [COUNT_BITS-1:0]  t_next;
	logic [SAMPLE_BITS-1:0] mag_l_q;
	logic [SAMPLE_BITS-1:0] mag_r_q;
	logic                   neg_l_q;
	logic                   neg_r_q;

	// phase select
	logic [CMP_W-1:0]  t_x;
	logic [CMP_W-1:0]  a_x;
	logic [CMP_W-1:0]  d_x;
	logic [CMP_W-1:0]  r_x;
	logic [CMP_W-1:0]  n_x;
	logic [LEN_W-1:0]  e_off;
	logic [LEN_W-1:0]  rel_span;
	logic [GAIN_W-1:0] mul_a;
	logic [LEN_W-1:0]  mul_b;
	logic [NUM_W-1:0]  add_v;
	logic [LEN_W-1:0]  div_v;
	logic              direct_v;
	logic [GAIN_W-1:0] dgain_v;

	logic [GAIN_W-1:0] mul_a_q;
	logic [LEN_W-1:0]  mul_b_q;
	logic [NUM_W-1:0]  add_q;
	logic [LEN_W-1:0]  div_q;
	logic              direct_q;
	logic [GAIN_W-1:0] dgain_q;
	logic              play_q;

	// divider
	logic [NUM_W-1:0]  num;
	logic [LEN_W-1:0]  rem_q;
	logic [GAIN_W-1:0] quo_q;
	logic [LEN_W:0]    rem_sh;
	logic [LEN_W+1:0]  trial;
	logic              borrow;

	logic [GG_W-1:0]        gg_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SAMPLE_BITS-1:0] res_l_q;
	result_t                result_q;

	function automatic logic [SAMPLE_BITS-1:0] round_sat(
		input logic [PROD_W-1:0] p,
		input logic              neg
	);
		logic [PROD_W:0]    sum;
		logic [RND_W-1:0]   r;
		logic [RND_W-1:0]   nr;
		sum = {1'b0, p} + ROUND_ADD;
		r   = sum[PROD_W:FRAC_BITS];
		if (neg) begin
			if (r > HALF) r = HALF;
			nr = ~r + 1'b1;
			return nr[SAMPLE_BITS-1:0];
		end
		if (r > HALF - 1'b1) r = HALF - 1'b1;
		return r[SAMPLE_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= RST_ATTACK_LEN;
			decay_len_q   <= RST_DECAY_LEN;
			release_len_q <= RST_RELEASE_LEN;
			note_len_q    <= RST_NOTE_LEN;
			peak_gain_q   <= RST_PEAK_GAIN;
			output_gain_q <= RST_OUTPUT_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTACK_LEN:  attack_len_q  <= cfg_data;
				REG_DECAY_LEN:   decay_len_q   <= cfg_data;
				REG_RELEASE_LEN: release_len_q <= cfg_data;
				REG_NOTE_LEN:    note_len_q    <= cfg_data;
				REG_PEAK_GAIN:   peak_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_OUTPUT_GAIN: output_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign t_next = sample.restart ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.take_in) begin
			// saturate so an ended note stays ended
			count_q <= (t_next != COUNT_MAX) ? t_next + 1'b1 : COUNT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			t_q     <= t_next;
			neg_l_q <= sample.left_in[SAMPLE_BITS-1];
			neg_r_q <= sample.right_in[SAMPLE_BITS-1];
			mag_l_q <= sample.left_in[SAMPLE_BITS-1] ?
				(~$unsigned(sample.left_in) + 1'b1) : $unsigned(sample.left_in);
			mag_r_q <= sample.right_in[SAMPLE_BITS-1] ?
				(~$unsigned(sample.right_in) + 1'b1) : $unsigned(sample.right_in);
		end
	end

	assign t_x      = CMP_W'(t_q);
	assign a_x      = CMP_W'(attack_len_q);
	assign d_x      = CMP_W'(decay_len_q);
	assign r_x      = CMP_W'(release_len_q);
	assign n_x      = CMP_W'(note_len_q);
	assign e_off    = LEN_W'(t_x - a_x);
	assign rel_span = LEN_W'(n_x - t_x);

	// numerator = mul_a * mul_b + add_v, quotient by div_v
	always_comb begin
		mul_a    = peak_gain_q;
		mul_b    = LEN_W'(t_x);
		add_v    = '0;
		div_v    = attack_len_q;
		direct_v = 1'b0;
		dgain_v  = UNITY_GAIN;
		if ((attack_len_q != '0) && (t_x < a_x)) begin
			div_v = attack_len_q;
		end else if ((decay_len_q != '0) && (t_x < a_x + d_x)) begin
			mul_b = decay_len_q - e_off;
			add_v = NUM_W'(e_off) << GAIN_FRAC;
			div_v = decay_len_q;
		end else if ((release_len_q != '0) && (t_x + r_x > n_x)) begin
			if (t_x >= n_x) begin
				direct_v = 1'b1;
				dgain_v  = '0;
			end else begin
				mul_a = UNITY_GAIN;
				mul_b = rel_span;
				div_v = release_len_q;
			end
		end else begin
			direct_v = 1'b1;
		end
	end

	assign num    = NUM_W'(mul_a_q) * NUM_W'(mul_b_q) + add_q;
	assign rem_sh = {rem_q, quo_q[GAIN_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, div_q};
	assign borrow = trial[LEN_W+1];

	always_ff @(posedge clk) begin
		if (cmd.eval_phase) begin
			mul_a_q  <= mul_a;
			mul_b_q  <= mul_b;
			add_q    <= add_v;
			div_q    <= div_v;
			direct_q <= direct_v;
			dgain_q  <= dgain_v;
			play_q   <= (t_x + CMP_W'(1)) < n_x;
		end
		if (cmd.load_num) begin
			if (direct_q) begin
				rem_q <= '0;
				quo_q <= dgain_q;
			end else begin
				rem_q <= num[NUM_W-1:GAIN_W];
				quo_q <= num[GAIN_W-1:0];
			end
		end
		if (cmd.div_step) begin
			rem_q <= borrow ? rem_sh[LEN_W-1:0] : trial[LEN_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], ~borrow};
		end
		if (cmd.load_gain) begin
			gg_q <= GG_W'(quo_q) * GG_W'(output_gain_q);
		end
		if (cmd.mul_left) begin
			prod_q <= PROD_W'(mag_l_q) * PROD_W'(gg_q);
		end
		if (cmd.mul_right) begin
			prod_q  <= PROD_W'(mag_r_q) * PROD_W'(gg_q);
			res_l_q <= round_sat(prod_q, neg_l_q);
		end
		if (cmd.load_out) begin
			result_q.left_out      <= res_l_q;
			result_q.right_out     <= round_sat(prod_q, neg_r_q);
			result_q.still_playing <= play_q;
		end
	end

	assign stat.direct = direct_q;
	assign result      = result_q;

endmodule

`default_nettype wire

// ----- rtl/core/adsr_envelope_stereo_core.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_stereo_core
// ADSR gain envelope on a stereo sample stream, saturated 16-bit output.
// ----------------------------------------------------------------------------
// Usage:
//   sample_valid/sample_ready carry one stereo request (restart flag plus left
//   and right samples); result_valid/result_ready return one enveloped pair
//   and a still_playing flag for every request, in order.
//   The configuration port writes register cfg_index with cfg_data whenever
//   cfg_we is high; write it only while no request is in flight.
// Sequence: an accepted request steps through phase select, numerator load,
//   the restoring divider when the gain needs a division (attack, decay,
//   release ramp; not sustain or past note end), gain product, left and
//   right scaling and the output load. sample_ready is high only while the
//   sequencer is idle: a request is taken only once the last has left it.
// Stall: the output register holds a finished result while the receiver
//   stalls; the next request is still accepted and runs until its own
//   result waits for the register to free up.
// Reset: arst_n clears the sample counter, loads the register defaults and
//   drops result_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_stereo_core
	import adsr_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  sample_valid,
	output logic                       sample_ready,
	input  wire sample_t               sample,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result
);

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: phase select, divide, gain product, per-channel scale
	adsr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// datapath: registers, counter, divider, multipliers, output register
	adsr_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire

// ----- tb/adsr_envelope_stereo_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adsr_envelope_stereo_core_tb
// Self-checking bench: a scoreboard tracks the note counter and register set,
// predicts every enveloped stereo pair, and checks results in order while
// both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module adsr_envelope_stereo_core_tb;
	import adsr_pkg::*;

	// indexes past the register map; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [LEN_W-1:0]          LEN_MAX  = '1;
	localparam logic [GAIN_W-1:0]         GAIN_MAX = '1;
	localparam logic [COUNT_BITS_DEF-1:0] CNT_MAX  = '1;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 71;
	localparam int DRAIN_CYCLES    = 30;
	localparam int RUN_LIMIT_NS    = 8_000_000;

	// ------------------------------------------------------------------------
	// Scoreboard: private copy of the registers and the sample counter.
	// ------------------------------------------------------------------------
	class envelope_scoreboard;
		logic [LEN_W-1:0]          attack_len, decay_len, release_len, note_len;
		logic [GAIN_W-1:0]         peak_gain, output_gain;
		logic [COUNT_BITS_DEF-1:0] count;
		result_t                   pairs_due[$];
		int                        errors;

		function new();
			attack_len  = RST_ATTACK_LEN;
			decay_len   = RST_DECAY_LEN;
			release_len = RST_RELEASE_LEN;
			note_len    = RST_NOTE_LEN;
			peak_gain   = RST_PEAK_GAIN;
			output_gain = RST_OUTPUT_GAIN;
			count       = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ATTACK_LEN:  attack_len  = data;
				REG_DECAY_LEN:   decay_len   = data;
				REG_RELEASE_LEN: release_len = data;
				REG_NOTE_LEN:    note_len    = data;
				REG_PEAK_GAIN:   peak_gain   = data[GAIN_W-1:0];
				REG_OUTPUT_GAIN: output_gain = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Q2.14 gain for sample position t
		function logic [63:0] envelope_gain(logic [63:0] t);
			logic [63:0] att, dec, rel, len, pk, e;
			att = 64'(attack_len);
			dec = 64'(decay_len);
			rel = 64'(release_len);
			len = 64'(note_len);
			pk  = 64'(peak_gain);
			if (att != 0 && t < att)
				return pk * t / att;
			if (dec != 0 && t < att + dec) begin
				e = t - att;
				return (pk * (dec - e) + 64'(UNITY_GAIN) * e) / dec;
			end
			if (rel != 0 && t + rel > len) begin
				if (t >= len)
					return 64'd0;
				return (len - t) * 64'(UNITY_GAIN) / rel;
			end
			return 64'(UNITY_GAIN);
		endfunction

		// scale by gain and output gain, round half away from zero, saturate
		function logic [SAMPLE_BITS-1:0] scale(logic [SAMPLE_BITS-1:0] x, logic [63:0] g);
			logic        neg;
			logic [63:0] half, mag;
			half = 64'd1 << (SAMPLE_BITS - 1);
			neg  = x[SAMPLE_BITS-1];
			mag  = neg ? (half << 1) - 64'(x) : 64'(x);
			mag  = (mag * g * 64'(output_gain) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (neg) begin
				if (mag > half)
					mag = half;
				return SAMPLE_BITS'(-mag);
			end
			if (mag > half - 1)
				mag = half - 1;
			return SAMPLE_BITS'(mag);
		endfunction

		function void take_sample(sample_t s);
			logic [63:0] t, g;
			result_t     r;
			t = s.restart ? 64'd0 : 64'(count);
			g = envelope_gain(t);
			r.left_out      = scale(s.left_in, g);
			r.right_out     = scale(s.right_in, g);
			r.still_playing = (t + 1 < 64'(note_len));
			count = (t == 64'(CNT_MAX)) ? CNT_MAX : COUNT_BITS_DEF'(t + 1);
			pairs_due.push_back(r);
		endfunction

		function void check_pair(result_t got);
			result_t want;
			if (pairs_due.size() == 0) begin
				$display("%0t: unexpected result %h, no request pending", $time, got);
				errors++;
				return;
			end
			want = pairs_due.pop_front();
			if (got.left_out !== want.left_out) begin
				$display("%0t: left_out expected %0d got %0d", $time,
					want.left_out, got.left_out);
				errors++;
			end
			if (got.right_out !== want.right_out) begin
				$display("%0t: right_out expected %0d got %0d", $time,
					want.right_out, got.right_out);
				errors++;
			end
			if (got.still_playing !== want.still_playing) begin
				$display("%0t: still_playing expected %0b got %0b", $time,
					want.still_playing, got.still_playing);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block under test
	// ------------------------------------------------------------------------
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_ATTACK_LEN;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               req_data     = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               res_data;

	// quiet flags switch off idling on one side for a whole phase
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	envelope_scoreboard board;

	always #5 clk = ~clk;

	adsr_envelope_stereo_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (req_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (res_data)
	);

	// Mostly back-to-back, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Full-scale values show up often enough to hit saturation on both rails.
	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 19))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request side. Raise valid with the payload, hold both until the edge
	// where ready is seen, note the request, then optionally drop valid for
	// an idle gap. With no gap, valid stays high into the next request.
	// ------------------------------------------------------------------------
	task automatic send_request(input logic rs, input logic [SAMPLE_BITS-1:0] l,
		input logic [SAMPLE_BITS-1:0] r);
		sample_t s;
		int      gap;
		s.restart  = rs;
		s.left_in  = l;
		s.right_in = r;
		sample_valid <= 1'b1;
		req_data     <= s;
		do @(posedge clk); while (!sample_ready);
		board.take_sample(s);
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every request has returned and the
	// sequencer is back to idle; register writes are safe after this.
	task automatic drain();
		if (sample_valid)
			sample_valid <= 1'b0;
		while (board.pairs_due.size() != 0 || !sample_ready)
			@(posedge clk);
	endtask

	// One register write per clock; the enable stays high across the batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		board.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Write the whole register set. Gain registers get random junk above
	// bit 15, and one write to an unmapped index must change nothing.
	task automatic load_setting(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] d,
		input logic [LEN_W-1:0] r, input logic [LEN_W-1:0] n,
		input logic [GAIN_W-1:0] pk, input logic [GAIN_W-1:0] og);
		write_reg(REG_ATTACK_LEN, a);
		write_reg(REG_DECAY_LEN, d);
		write_reg(REG_RELEASE_LEN, r);
		write_reg(REG_NOTE_LEN, n);
		write_reg(REG_PEAK_GAIN, {8'($urandom), pk});
		write_reg(REG_OUTPUT_GAIN, {8'($urandom), og});
		write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result side: check every accepted result, then pick ready for the next
	// cycle. A stall holds ready low; otherwise ready goes high and the next
	// stall is drawn.
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				board.check_pair(res_data);
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				stall = pick_gap(rx_quiet);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int                n;
		int                span;
		logic              rs;
		logic [LEN_W-1:0]  a, d, r, nl;
		logic [GAIN_W-1:0] pk, og;

		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register set: a note start and full-scale inputs early in attack.
		send_request(1'b1, 16'h7FFF, 16'h8000);
		send_request(1'b0, 16'h0000, 16'hFFFF);
		send_request(1'b0, 16'h0001, 16'h7FFF);
		send_request(1'b0, 16'h8000, 16'h8000);
		drain();

		// Short envelope at maximum gains: one note walks through attack,
		// decay, sustain, release and past its end, with rails on the inputs.
		load_setting(24'd4, 24'd3, 24'd5, 24'd16, GAIN_MAX, GAIN_MAX);
		for (int i = 0; i < 20; i++) begin
			case (i % 5)
				0: send_request(i == 0, 16'h7FFF, 16'h8000);
				1: send_request(1'b0, 16'h8000, 16'h7FFF);
				2: send_request(1'b0, 16'h0000, 16'hFFFF);
				3: send_request(1'b0, 16'hFFFF, 16'h0001);
				default: send_request(1'b0, rand_sample(), rand_sample());
			endcase
		end

		// Random phases, one register set each. Most traffic is whole notes
		// that start with a restart; a few notes run on from the previous
		// count and a few carry a stray restart partway through.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			tx_quiet = (p % 4 == 1);
			rx_quiet = (p % 4 == 2);
			a  = LEN_W'($urandom_range(0, 8));
			d  = LEN_W'($urandom_range(0, 8));
			r  = LEN_W'($urandom_range(0, 10));
			nl = LEN_W'($urandom_range(0, 40));
			pk = GAIN_W'($urandom);
			og = GAIN_W'($urandom);
			case (p)
				// no phases at all: unity gain throughout
				0: begin
					a  = '0;
					d  = '0;
					r  = '0;
					og = UNITY_GAIN;
				end
				// peak below unity: decay rises toward unity
				1: begin
					a  = '0;
					d  = LEN_W'($urandom_range(1, 10));
					r  = LEN_W'($urandom_range(1, 6));
					nl = LEN_W'($urandom_range(12, 30));
					pk = GAIN_W'($urandom_range(0, UNITY_GAIN - 1));
				end
				// every register at its top value
				2: begin
					a  = LEN_MAX;
					d  = LEN_MAX;
					r  = LEN_MAX;
					nl = LEN_MAX;
					pk = GAIN_MAX;
					og = GAIN_MAX;
				end
				// zero-length note: never still playing; past the end after attack and decay
				3: begin
					a  = 24'd2;
					d  = 24'd2;
					r  = 24'd5;
					nl = '0;
				end
				// both gains at zero
				4: begin
					pk = '0;
					og = '0;
				end
				// release longer than the note
				5: begin
					a  = LEN_W'($urandom_range(0, 3));
					r  = LEN_W'($urandom_range(20, 40));
					nl = LEN_W'($urandom_range(5, 15));
				end
				6: og = GAIN_MAX;
				7: begin
					a  = 24'd1;
					d  = 24'd1;
					r  = 24'd1;
					nl = LEN_W'($urandom_range(2, 10));
					pk = GAIN_MAX;
					og = UNITY_GAIN;
				end
				default: ;
			endcase
			load_setting(a, d, r, nl, pk, og);

			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				span = ((nl < 40) ? int'(nl) : 40) + $urandom_range(1, 6);
				for (int i = 0; i < span && n < ITEMS_PER_PHASE; i++) begin
					if (i == 0)
						rs = ($urandom_range(0, 9) != 0);
					else
						rs = ($urandom_range(0, 99) < 8);
					send_request(rs, rand_sample(), rand_sample());
					n++;
				end
			end
		end

		// Let the last results come back, then watch for strays.
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop if a handshake never completes.
	initial begin
		#RUN_LIMIT_NS;
		$display("Regression FAIL");
		$finish;
	end

endmodule
